>>> rtl/masked_signature_scan_defines.svh
// Assertion helpers used by the checker in mss_chk.sv.
`ifndef MASKED_SIGNATURE_SCAN_DEFINES_SVH
`define MASKED_SIGNATURE_SCAN_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define MSS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("masked_signature_scan: assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define MSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("masked_signature_scan: assertion failed");

// Next-cycle implication that also holds across reset.
`define MSS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("masked_signature_scan: assertion failed");

`endif

>>> rtl/mss_pkg.sv
package mss_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int COUNT_BITS  = 32;

  localparam int BYTE_W    = 8;
  localparam int ADDR_W    = 48;
  localparam int CFG_LEN_W = 7;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 48;

  localparam int CELL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);

  // Input tdata layout, lowest bit first.
  localparam int IDX_LSB   = 0;
  localparam int PAT_LSB   = IDX_LSB + IDX_W;
  localparam int MSK_LSB   = PAT_LSB + BYTE_W;
  localparam int DAT_LSB   = MSK_LSB + BYTE_W;
  localparam int IN_DATA_W = ((DAT_LSB + BYTE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ADDR_W + 7) / 8) * 8;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_SCAN = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 1'b0,
    CFG_BASE_ADDRESS   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pat;
    logic [BYTE_W-1:0] msk;
  } pm_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic              shift;
    logic              rot_up;
    logic              rot_dn;
    logic              load;
    logic [CELL_W-1:0] wcell;
    logic [LEN_W-1:0]  alen;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] pat;
    logic [BYTE_W-1:0] msk;
  } cell_ctrl_t;

  // Pattern length as used: zero counts as one, large values are capped.
  function automatic logic [LEN_W-1:0] used_len(input logic [CFG_LEN_W-1:0] v);
    int n;
    n = int'(v);
    if (n == 0) n = 1;
    else if (n > PATTERN_MAX) n = PATTERN_MAX;
    return LEN_W'(n);
  endfunction

  // Pattern entry idx lives in cell (alen - 1 - idx) mod PATTERN_MAX.
  function automatic logic [CELL_W-1:0] wr_cell(input logic [LEN_W-1:0] alen,
                                                input logic [IDX_W-1:0] idx);
    int d;
    d = int'(alen) - 1 - int'(idx);
    if (d < 0) d = d + PATTERN_MAX;
    return CELL_W'(d);
  endfunction

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return int'(idx) < PATTERN_MAX;
  endfunction

endpackage

>>> rtl/masked_signature_scan.sv
// An accepted scan item enters the window and scan stage, then its result is registered.
// One item per cycle while the pattern is aligned and no result is stalled at the output;
// the whole window is compared at once by the cell row. A pattern_length write holds off
// input while the pattern entries rotate one cell per cycle into their new alignment.
// Reset (rst_n low, synchronous) clears configuration, counters and handshake state;
// pattern and mask entries stay undefined until loaded.
module masked_signature_scan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // entry_index, pattern_byte, mask_byte, data_byte, zero fill
  input  logic [mss_pkg::IN_DATA_W-1:0]      in_tdata,
  // req_type
  input  logic [0:0]                         in_tuser,
  input  logic                               in_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mss_pkg::CFG_W-1:0]          cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // match_address
  output logic [mss_pkg::OUT_DATA_W-1:0]     out_tdata,
  // found
  output logic [0:0]                         out_tuser
);
  import mss_pkg::*;

  cell_ctrl_t             ctl;
  logic [BYTE_W-1:0]      win [PATTERN_MAX];
  pm_t                    pm  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] ok;
  logic [PATTERN_MAX-1:0] load_en;
  logic [PATTERN_MAX-1:0] active;
  logic                   match_all;

  mss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .match_all  (match_all),
    .ctl        (ctl)
  );

  // Cell 0 holds the newest byte; the window moves up the row one cell per item,
  // and the pattern entries rotate around the row when the length changes.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    localparam int PREV = (i + PATTERN_MAX - 1) % PATTERN_MAX;
    localparam int NEXT = (i + 1) % PATTERN_MAX;
    logic [BYTE_W-1:0] win_in;

    if (i == 0) begin : g_head
      assign win_in = ctl.data;
    end else begin : g_body
      assign win_in = win[PREV];
    end

    assign load_en[i] = ctl.load && (ctl.wcell == CELL_W'(i));
    assign active[i]  = (LEN_W'(i) < ctl.alen);

    mss_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_en  (load_en[i]),
      .active   (active[i]),
      .win_prev (win_in),
      .pm_prev  (pm[PREV]),
      .pm_next  (pm[NEXT]),
      .win_q    (win[i]),
      .pm_q     (pm[i]),
      .ok       (ok[i])
    );
  end

  assign match_all = &ok;

endmodule

>>> rtl/mss_cell.sv
module mss_cell (
  input  logic                            clk,
  input  mss_pkg::cell_ctrl_t             ctl,
  input  logic                            load_en,
  input  logic                            active,
  input  logic [mss_pkg::BYTE_W-1:0]      win_prev,
  input  mss_pkg::pm_t                    pm_prev,
  input  mss_pkg::pm_t                    pm_next,
  output logic [mss_pkg::BYTE_W-1:0]      win_q,
  output mss_pkg::pm_t                    pm_q,
  output logic                            ok
);
  import mss_pkg::*;

  logic [BYTE_W-1:0] win_r, win_nxt;
  pm_t               pm_r, pm_nxt;

  always_comb begin
    win_nxt = ctl.shift ? win_prev : win_r;
    if (load_en) begin
      pm_nxt = '{pat: ctl.pat, msk: ctl.msk};
    end else if (ctl.rot_up) begin
      pm_nxt = pm_prev;
    end else if (ctl.rot_dn) begin
      pm_nxt = pm_next;
    end else begin
      pm_nxt = pm_r;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    pm_r  <= pm_nxt;
  end

  assign win_q = win_r;
  assign pm_q  = pm_r;
  // Cells past the pattern length never block a match.
  assign ok    = !active || ((win_r & pm_r.msk) == pm_r.pat);

endmodule

>>> rtl/mss_ctrl.sv
module mss_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mss_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [0:0]                         in_tuser,
  input  logic                               in_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mss_pkg::CFG_W-1:0]          cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mss_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [0:0]                         out_tuser,
  input  logic                               match_all,
  output mss_pkg::cell_ctrl_t                ctl
);
  import mss_pkg::*;

  logic [CFG_LEN_W-1:0]  len_cfg_r, len_cfg_nxt;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [LEN_W-1:0]      alen_r, alen_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  match_seen_r, match_seen_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_check_r, s1_check_nxt;
  logic                  s1_last_r, s1_last_nxt;
  logic [COUNT_BITS-1:0] s1_off_r, s1_off_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;

  logic [LEN_W-1:0]      target;
  logic                  aligned, s1_adv, acc, scan_acc, load_acc;
  logic                  rot_up, rot_dn;
  logic [IDX_W-1:0]      f_idx;
  logic                  checkable, hit, miss, emit;
  logic [COUNT_BITS-1:0] cnt_inc, len_ext;

  assign target  = used_len(len_cfg_r);
  assign aligned = (alen_r == target);
  assign rot_up  = !aligned && (alen_r < target);
  assign rot_dn  = !aligned && (alen_r > target);

  // The scan stage may move on unless a result waits in the output register and is not taken.
  assign s1_adv    = !s1_valid_r || !out_valid_r || out_tready;
  assign in_tready = aligned && s1_adv;
  assign cfg_ready = 1'b1;

  assign acc      = in_tvalid && in_tready;
  assign f_idx    = in_tdata[IDX_LSB +: IDX_W];
  assign scan_acc = acc && (req_t'(in_tuser[0]) == REQ_SCAN);
  assign load_acc = acc && (req_t'(in_tuser[0]) == REQ_LOAD) && idx_ok(f_idx);

  assign checkable = (count_r != '1);
  assign cnt_inc   = checkable ? count_r + COUNT_BITS'(1) : count_r;
  assign len_ext   = COUNT_BITS'(alen_r);

  assign hit  = s1_valid_r && s1_adv && s1_check_r && !match_seen_r && match_all;
  assign miss = s1_valid_r && s1_adv && s1_last_r && !match_seen_r && !hit;
  assign emit = hit || miss;

  always_comb begin
    len_cfg_nxt = len_cfg_r;
    base_nxt    = base_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_LENGTH: len_cfg_nxt = cfg_data[CFG_LEN_W-1:0];
        CFG_BASE_ADDRESS:   base_nxt    = cfg_data[ADDR_W-1:0];
        default:            len_cfg_nxt = len_cfg_r;
      endcase
    end

    alen_nxt = alen_r;
    if (rot_up) alen_nxt = alen_r + LEN_W'(1);
    else if (rot_dn) alen_nxt = alen_r - LEN_W'(1);

    count_nxt    = count_r;
    s1_valid_nxt = s1_valid_r;
    s1_check_nxt = s1_check_r;
    s1_last_nxt  = s1_last_r;
    s1_off_nxt   = s1_off_r;
    if (scan_acc) begin
      count_nxt    = in_tlast ? '0 : cnt_inc;
      s1_valid_nxt = 1'b1;
      s1_check_nxt = checkable && (cnt_inc >= len_ext);
      s1_last_nxt  = in_tlast;
      s1_off_nxt   = cnt_inc - len_ext;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    match_seen_nxt = match_seen_r;
    if (s1_valid_r && s1_adv) begin
      match_seen_nxt = s1_last_r ? 1'b0 : (match_seen_r || hit);
    end

    out_valid_nxt = (out_valid_r && !out_tready) || emit;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (emit) begin
      out_found_nxt = hit;
      out_addr_nxt  = hit ? base_r + ADDR_W'(s1_off_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r    <= CFG_LEN_W'(1);
      base_r       <= '0;
      alen_r       <= LEN_W'(1);
      count_r      <= '0;
      match_seen_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      len_cfg_r    <= len_cfg_nxt;
      base_r       <= base_nxt;
      alen_r       <= alen_nxt;
      count_r      <= count_nxt;
      match_seen_r <= match_seen_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_check_r  <= s1_check_nxt;
    s1_last_r   <= s1_last_nxt;
    s1_off_r    <= s1_off_nxt;
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_addr_r);
  assign out_tuser  = out_found_r;

  assign ctl.shift  = scan_acc;
  assign ctl.rot_up = rot_up;
  assign ctl.rot_dn = rot_dn;
  assign ctl.load   = load_acc;
  assign ctl.wcell  = wr_cell(alen_r, f_idx);
  assign ctl.alen   = alen_r;
  assign ctl.data   = in_tdata[DAT_LSB +: BYTE_W];
  assign ctl.pat    = in_tdata[PAT_LSB +: BYTE_W];
  assign ctl.msk    = in_tdata[MSK_LSB +: BYTE_W];

endmodule

>>> rtl/mss_chk.sv
`include "masked_signature_scan_defines.svh"

module mss_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [mss_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                     out_tuser
);

  // A result that is not taken stays put until it is.
  `MSS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // A region that ended without a match reports address zero.
  `MSS_ASSERT_IMPLY(a_miss_zero, out_tvalid && !out_tuser[0], out_tdata == '0)

  // Reset empties the output register.
  `MSS_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid)

endmodule

bind masked_signature_scan mss_chk u_mss_chk (.*);

>>> tb/sv/mss_scan_checker.sv
module mss_scan_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // entry_index, pattern_byte, mask_byte, data_byte, zero fill
  input  logic [mss_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [0:0]                     in_tuser,
  input  logic                           in_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mss_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // match_address
  input  logic [mss_pkg::OUT_DATA_W-1:0] out_tdata,
  // found
  input  logic [0:0]                     out_tuser,
  output int                             mismatch_count,
  output int                             pending_reports
);
  import mss_pkg::*;

  typedef struct {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_report_t;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  logic [BYTE_W-1:0]     sig_pat [PATTERN_MAX];
  logic [BYTE_W-1:0]     sig_msk [PATTERN_MAX];
  logic [BYTE_W-1:0]     window [PATTERN_MAX];
  logic [COUNT_BITS-1:0] bytes_seen;
  logic                  hit_seen;
  logic [CFG_LEN_W-1:0]  len_reg;
  logic [ADDR_W-1:0]     base_reg;
  scan_report_t          expected_reports[$];
  scan_report_t          got_report;
  logic [IDX_W-1:0]      load_idx;
  int                    errors = 0;

  assign mismatch_count = errors;

  always @(negedge clk) pending_reports <= expected_reports.size();

  function automatic int active_length();
    int n;
    n = int'(len_reg);
    if (n == 0) n = 1;
    else if (n > PATTERN_MAX) n = PATTERN_MAX;
    return n;
  endfunction

  // window[0] holds the newest byte, so pattern entry j lines up with window[n-1-j].
  function automatic bit window_hit(input int n);
    for (int j = 0; j < n; j++) begin
      if ((window[n-1-j] & sig_msk[j]) != sig_pat[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    for (int k = 0; k < PATTERN_MAX; k++) window[k] = '0;
    bytes_seen = '0;
    hit_seen = 1'b0;
  endtask

  task automatic take_scan_byte(input logic [BYTE_W-1:0] dat, input logic last);
    int n;
    logic counting;
    scan_report_t rep;
    for (int k = PATTERN_MAX - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = dat;
    // Once the counter is pinned at its top value, no position is checked any more.
    counting = (bytes_seen != COUNT_TOP);
    if (counting) bytes_seen = bytes_seen + 1'b1;
    n = active_length();
    if (counting && !hit_seen && bytes_seen >= n && window_hit(n)) begin
      hit_seen = 1'b1;
      rep.found = 1'b1;
      rep.addr = base_reg + ADDR_W'(bytes_seen - COUNT_BITS'(n));
      expected_reports.push_back(rep);
    end
    if (last) begin
      if (!hit_seen) begin
        rep.found = 1'b0;
        rep.addr = '0;
        expected_reports.push_back(rep);
      end
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      len_reg = CFG_LEN_W'(1);
      base_reg = '0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN_LENGTH: len_reg = cfg_data[CFG_LEN_W-1:0];
          CFG_BASE_ADDRESS:   base_reg = cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (req_t'(in_tuser[0]) == REQ_LOAD) begin
          load_idx = in_tdata[IDX_LSB +: IDX_W];
          if (int'(load_idx) < PATTERN_MAX) begin
            sig_pat[load_idx] = in_tdata[PAT_LSB +: BYTE_W];
            sig_msk[load_idx] = in_tdata[MSK_LSB +: BYTE_W];
          end
        end else begin
          take_scan_byte(in_tdata[DAT_LSB +: BYTE_W], in_tlast);
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          $error("found/match_address: item with none expected, got %0d / %h",
                 out_tuser[0], out_tdata[ADDR_W-1:0]);
          errors++;
        end else begin
          got_report = expected_reports.pop_front();
          if (out_tuser[0] !== got_report.found) begin
            $error("found: expected %0d, got %0d", got_report.found, out_tuser[0]);
            errors++;
          end
          if (out_tdata[ADDR_W-1:0] !== got_report.addr) begin
            $error("match_address: expected %h, got %h", got_report.addr,
                   out_tdata[ADDR_W-1:0]);
            errors++;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_masked_signature_scan.sv
module tb_masked_signature_scan;
  import mss_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_ITEMS    = 760;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int BURST_ITEMS     = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // entry_index, pattern_byte, mask_byte, data_byte, zero fill
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // req_type
  logic [0:0]            in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // match_address
  logic [OUT_DATA_W-1:0] out_tdata;
  // found
  logic [0:0]            out_tuser;

  int mismatch_count;
  int pending_reports;
  int cycle_count = 0;
  int items_sent = 0;
  int cur_len = 1;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  logic [7:0] tb_pat [PATTERN_MAX];
  logic [7:0] tb_msk [PATTERN_MAX];

  always #2 clk = ~clk;

  masked_signature_scan dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  mss_scan_checker scan_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .mismatch_count(mismatch_count), .pending_reports(pending_reports)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_masked_signature_scan NOT OK");
      $finish;
    end
  end

  // Result side: random stalls per item, plus one long hold-off on request.
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 7) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if ($urandom_range(0, 29) == 0) rx_idle_on = !rx_idle_on;
    end
  end

  task automatic send_item(input req_t req, input logic [IDX_W-1:0] idx,
                           input logic [7:0] pat, input logic [7:0] msk,
                           input logic [7:0] dat, input logic last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tlast  <= last;
    in_tdata  <= {{(IN_DATA_W - DAT_LSB - BYTE_W){1'b0}}, dat, msk, pat, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_entry(input int idx, input logic [7:0] pat, input logic [7:0] msk);
    tb_pat[idx] = pat;
    tb_msk[idx] = msk;
    send_item(REQ_LOAD, IDX_W'(idx), pat, msk, 8'($urandom), 1'($urandom));
  endtask

  task automatic scan_byte(input logic [7:0] dat, input logic last);
    send_item(REQ_SCAN, IDX_W'($urandom), 8'($urandom), 8'($urandom), dat, last);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all expected results, then give a scan with no result time to finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_length(input int v);
    write_cfg(CFG_PATTERN_LENGTH, CFG_W'(v));
    cur_len = (v == 0) ? 1 : ((v > PATTERN_MAX) ? PATTERN_MAX : v);
  endtask

  task automatic random_entry(input int idx);
    logic [7:0] msk;
    logic [7:0] pat;
    msk = ($urandom_range(0, 9) < 6) ? 8'hFF : 8'($urandom);
    pat = 8'($urandom) & msk;
    // Now and then a pattern bit sits under a clear mask bit and can never match.
    if ($urandom_range(0, 29) == 0) pat = 8'($urandom);
    load_entry(idx, pat, msk);
  endtask

  task automatic scan_region(input int n, input bit plant, input bit spoil,
                             input bit with_loads);
    logic [7:0] region [256];
    int start_at;
    int j;
    for (int k = 0; k < n; k++) region[k] = 8'($urandom);
    if (plant && n >= cur_len) begin
      start_at = $urandom_range(0, n - cur_len);
      for (j = 0; j < cur_len; j++)
        region[start_at + j] = tb_pat[j] | (8'($urandom) & ~tb_msk[j]);
      if (spoil) begin
        j = $urandom_range(0, cur_len - 1);
        region[start_at + j] ^= (tb_msk[j] != 8'h00) ? tb_msk[j] : 8'h01;
      end
    end
    for (int k = 0; k < n; k++) begin
      if (with_loads && $urandom_range(0, 15) == 0) random_entry($urandom_range(0, 63));
      scan_byte(region[k], k == n - 1);
    end
  endtask

  initial begin
    int len_plan [6];
    int stop_at;
    int phase_end;
    int p;
    int v;
    int r;
    logic [ADDR_W-1:0] b;

    len_plan = '{0, 127, 64, 65, 2, 1};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every entry is written once so no later length reads an unwritten one.
    for (int j = 0; j < PATTERN_MAX; j++) random_entry(j);

    // Single-byte pattern: match mid-region, quiet bytes after it, one-byte region.
    load_entry(0, 8'hFF, 8'hFF);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'hFF, 1'b1);
    scan_byte(8'h12, 1'b1);
    load_entry(0, 8'h01, 8'h00);
    scan_byte(8'hFF, 1'b1);
    load_entry(0, 8'h00, 8'h00);
    scan_byte(8'h00, 1'b1);
    settle();
    set_length(3);
    load_entry(1, 8'h00, 8'h00);
    load_entry(2, 8'h00, 8'h00);
    // Region shorter than the pattern, then a match on the final byte.
    scan_byte(8'hAA, 1'b0);
    scan_byte(8'h55, 1'b1);
    scan_byte(8'h01, 1'b0);
    scan_byte(8'h02, 1'b0);
    scan_byte(8'h03, 1'b1);
    settle();
    write_cfg(CFG_BASE_ADDRESS, '1);
    load_entry(0, 8'h80, 8'h80);
    // Match at offset one from the top address wraps around to zero.
    scan_byte(8'h00, 1'b0);
    scan_byte(8'h80, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'h00, 1'b1);

    // Every byte matches while the result side holds off, so the input backs up.
    settle();
    set_length(1);
    write_cfg(CFG_BASE_ADDRESS, 48'h0000_1234_5678);
    load_entry(0, 8'h00, 8'h00);
    hold_off_req = 1'b1;
    tx_idle_on = 1'b0;
    repeat (BURST_ITEMS) scan_byte(8'($urandom), 1'b1);
    tx_idle_on = 1'b1;

    stop_at = items_sent + RANDOM_ITEMS;
    p = 0;
    while (items_sent < stop_at) begin
      settle();
      if (p < 6) v = len_plan[p];
      else if ($urandom_range(0, 11) == 0) v = $urandom_range(13, 127);
      else v = $urandom_range(1, 12);
      set_length(v);
      case (p % 4)
        0: b = '1;
        1: b = '0;
        2: b = 48'hFFFF_FFFF_FF00 | ADDR_W'($urandom_range(0, 255));
        default: b = {16'($urandom), 32'($urandom)};
      endcase
      write_cfg(CFG_BASE_ADDRESS, b);
      for (int j = 0; j < cur_len; j++) random_entry(j);
      phase_end = items_sent + 60;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 5) == 0) tx_idle_on = !tx_idle_on;
        r = $urandom_range(0, 9);
        scan_region($urandom_range(1, 2 * cur_len + 6), r < 8, r >= 6,
                    $urandom_range(0, 3) == 0);
      end
      p++;
    end

    settle();
    if (mismatch_count == 0 && pending_reports == 0) begin
      $display("tb_masked_signature_scan OK");
    end else begin
      $display("tb_masked_signature_scan NOT OK");
    end
    $finish;
  end

endmodule
